/* src/dru_pkg.sv */
// Shared types, constants and the sine table builder for the dead reckoning unit.
package dru_pkg;

   localparam int DEFAULT_SINE_DEPTH = 256;
   localparam int ROM_ADDR_W = 13;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] STEP_TIME_RESET = 16'd655;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   // Which table entry to read and whether the magnitude is negated.
   typedef struct packed {
      logic [ROM_ADDR_W-1:0] addr;
      logic                  neg;
   } trig_sel_type;

   // One classified sample as it waits between the front and the back.
   typedef struct packed {
      logic signed [15:0] speed;
      logic [15:0]        heading;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] depth;
      logic [15:0]        roll;
      logic [15:0]        pitch;
      trig_sel_type       sin_sel;
      trig_sel_type       cos_sel;
   } work_type;

   // Table entry for an angle in Q30 radians: a nine term Taylor series of the sine,
   // rounded to unsigned Q1.16 and clamped to one. Only evaluated at elaboration.
   function automatic logic [16:0] sine_entry(input logic [63:0] ang);
      logic [63:0]        term;
      logic signed [64:0] sum;
      logic signed [64:0] rnd;
      term = ang;
      sum  = $signed({1'b0, ang});
      for (int n = 1; n <= 8; n++) begin
         term = (term * ang) >> 30;
         term = (term * ang) >> 30;
         case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if (n[0]) begin
            sum = sum - $signed({1'b0, term});
         end else begin
            sum = sum + $signed({1'b0, term});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      rnd = (sum + 65'sd8192) >>> 14;
      if (rnd > 65'sd65536) begin
         rnd = 65'sd65536;
      end
      return rnd[16:0];
   endfunction

endpackage

/* src/dead_reckoning_position_update_unit.sv */
// Top level of the dead reckoning position integrator.
//
//   channel   direction  handshake        word
//   req_      in         push / full      one sensor sample
//   rsp_      out        empty / pop      updated position and passed-through angles
//   csr_      in         write enable     step time, unsigned Q0.16
//
// Each sample is worked through by the back end's step sequencer, which shares one
// 35 x 18 multiplier and one registered sine table read port; a 2-word queue in front
// takes new samples while the back end works. Reset clears position to zero, sets the
// step time to 655 and empties the queue and the result register. A result left unread
// holds the back end in its last step; the queue keeps accepting until it is full.
module dead_reckoning_position_update_unit import dru_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_speed,
   input  logic [15:0]        req_heading,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_depth_in,
   input  logic [15:0]        req_roll_in,
   input  logic [15:0]        req_pitch_in,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_depth_out,
   output logic [15:0]        rsp_roll_out,
   output logic [15:0]        rsp_pitch_out,
   output logic [15:0]        rsp_heading_out,
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data
);

   logic     q_pop;
   logic     q_empty;
   work_type q_head;

   dru_front #(
      .SINE_DEPTH (SINE_TABLE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_speed    (req_speed),
      .req_heading  (req_heading),
      .req_accel_x  (req_accel_x),
      .req_accel_y  (req_accel_y),
      .req_depth_in (req_depth_in),
      .req_roll_in  (req_roll_in),
      .req_pitch_in (req_pitch_in),
      .q_pop        (q_pop),
      .q_empty      (q_empty),
      .q_head       (q_head)
   );

   dru_back #(
      .SINE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_depth_out   (rsp_depth_out),
      .rsp_roll_out    (rsp_roll_out),
      .rsp_pitch_out   (rsp_pitch_out),
      .rsp_heading_out (rsp_heading_out)
   );

endmodule

/* src/dru_front.sv */
// Front end: accepts samples, works out the table lookups and queues the words.
module dru_front import dru_pkg::*; #(
   parameter int SINE_DEPTH = DEFAULT_SINE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_speed,
   input  logic [15:0]        req_heading,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_depth_in,
   input  logic [15:0]        req_roll_in,
   input  logic [15:0]        req_pitch_in,
   input  logic               q_pop,
   output logic               q_empty,
   output work_type           q_head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Folds a quadrant and an index within it onto the quarter-wave table.
   function automatic trig_sel_type fold(input logic [1:0] quad,
                                         input logic [ROM_ADDR_W-1:0] idx);
      trig_sel_type sel;
      sel.addr = quad[0] ? (ROM_ADDR_W'(SINE_DEPTH) - idx) : idx;
      sel.neg  = quad[1];
      return sel;
   endfunction

   logic [26:0]           scaled;
   logic [ROM_ADDR_W-1:0] idx;
   logic [1:0]            cos_quad;
   work_type              word;

   work_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  wr_en;
   logic                  rd_en;

   // Cosine is the sine a quarter turn ahead, so only the quadrant differs.
   assign scaled   = 27'(req_heading[13:0]) * 27'(SINE_DEPTH);
   assign idx      = scaled[26:14];
   assign cos_quad = req_heading[15:14] + 2'd1;

   always_comb begin
      word.speed   = req_speed;
      word.heading = req_heading;
      word.accel_x = req_accel_x;
      word.accel_y = req_accel_y;
      word.depth   = req_depth_in;
      word.roll    = req_roll_in;
      word.pitch   = req_pitch_in;
      word.sin_sel = fold(req_heading[15:14], idx);
      word.cos_sel = fold(cos_quad, idx);
   end

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entries_ff[rd_ptr_ff];
   assign wr_en   = push && !full;
   assign rd_en   = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

/* src/dru_back.sv */
// Back end: step sequencer with one shared multiplier, position update and result register.
module dru_back import dru_pkg::*; #(
   parameter int SINE_DEPTH = DEFAULT_SINE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data,
   input  logic               q_empty,
   input  work_type           q_head,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_depth_out,
   output logic [15:0]        rsp_roll_out,
   output logic [15:0]        rsp_pitch_out,
   output logic [15:0]        rsp_heading_out
);

   localparam int IDX_W = $clog2(SINE_DEPTH + 1);

   localparam logic [3:0] ST_SQUARE = 4'd0;
   localparam logic [3:0] ST_COS    = 4'd1;
   localparam logic [3:0] ST_SIN    = 4'd2;
   localparam logic [3:0] ST_VELX   = 4'd3;
   localparam logic [3:0] ST_VELY   = 4'd4;
   localparam logic [3:0] ST_ACCX   = 4'd5;
   localparam logic [3:0] ST_ACCY   = 4'd6;
   localparam logic [3:0] ST_ROUNDX = 4'd7;
   localparam logic [3:0] ST_ROUNDY = 4'd8;
   localparam logic [3:0] ST_WRITE  = 4'd9;

   localparam logic signed [50:0] ROUND_HALF = 51'sd16777216;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                  input logic signed [25:0] inc);
      logic signed [32:0] sum;
      sum = 33'(pos) + 33'(inc);
      if (sum[32] != sum[31]) begin
         return sum[32] ? POS_MIN : POS_MAX;
      end
      return sum[31:0];
   endfunction

   logic [16:0]           sine_rom [SINE_DEPTH + 1];

   logic [15:0]           step_time_ff;
   logic [3:0]            step_ff, step_in;
   logic [16:0]           rom_q_ff;
   logic [ROM_ADDR_W-1:0] rom_addr;
   logic signed [17:0]    trig;
   logic                  trig_neg;
   logic signed [34:0]    mul_a;
   logic signed [17:0]    mul_b;
   logic signed [52:0]    prod_in;
   logic signed [52:0]    prod_ff;
   logic signed [33:0]    tmp_ff;
   logic [31:0]           dtsq_ff;
   logic signed [50:0]    acc_x_ff, acc_y_ff;
   logic signed [50:0]    rnd_x, rnd_y;
   logic signed [25:0]    inc_x_ff, inc_y_ff;
   logic signed [31:0]    pos_x_ff, pos_y_ff;
   logic signed [31:0]    new_pos_y;
   logic                  out_valid_ff, out_valid_in;
   logic                  active;
   logic                  out_free;
   logic                  load_out;

   // Quarter-wave table, fixed at elaboration.
   for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] ANG_Q30 = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
      assign sine_rom[k] = sine_entry(ANG_Q30);
   end

   assign active   = !q_empty;
   assign out_free = !out_valid_ff || pop;
   assign load_out = active && (step_ff == ST_WRITE) && out_free;
   assign q_pop    = load_out;
   assign empty    = !out_valid_ff;

   // The cosine is read while the sequence starts, the sine in the step after it.
   assign rom_addr = (step_ff == ST_SQUARE) ? q_head.cos_sel.addr : q_head.sin_sel.addr;
   assign trig_neg = (step_ff == ST_COS) ? q_head.cos_sel.neg : q_head.sin_sel.neg;
   assign trig     = trig_neg ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});

   always_comb begin
      case (step_ff)
         ST_COS, ST_SIN: begin
            mul_a = 35'(trig);
            mul_b = 18'(q_head.speed);
         end
         ST_VELX, ST_VELY: begin
            mul_a = 35'(tmp_ff);
            mul_b = $signed({2'b00, step_time_ff});
         end
         ST_ACCX: begin
            mul_a = $signed({3'b000, dtsq_ff});
            mul_b = 18'(q_head.accel_x);
         end
         ST_ACCY: begin
            mul_a = $signed({3'b000, dtsq_ff});
            mul_b = 18'(q_head.accel_y);
         end
         default: begin
            mul_a = $signed({19'd0, step_time_ff});
            mul_b = $signed({2'b00, step_time_ff});
         end
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign rnd_x     = acc_x_ff + ROUND_HALF;
   assign rnd_y     = acc_y_ff + ROUND_HALF;
   assign new_pos_y = sat_add(pos_y_ff, inc_y_ff);

   always_comb begin
      step_in = step_ff;
      if (!active) begin
         step_in = ST_SQUARE;
      end else if (step_ff == ST_WRITE) begin
         if (out_free) begin
            step_in = ST_SQUARE;
         end
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         step_ff      <= ST_SQUARE;
         out_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            step_time_ff <= csr_write_data;
         end
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         if (active && (step_ff == ST_ROUNDY)) begin
            pos_x_ff <= sat_add(pos_x_ff, inc_x_ff);
         end
         if (load_out) begin
            pos_y_ff <= new_pos_y;
         end
      end
   end

   // Product register feeds the next step; partial sums collect in the accumulators.
   always_ff @(posedge clock) begin
      rom_q_ff <= sine_rom[rom_addr[IDX_W-1:0]];
      prod_ff  <= prod_in;
      case (step_ff)
         ST_COS: begin
            dtsq_ff <= prod_ff[31:0];
         end
         ST_SIN, ST_VELX: begin
            tmp_ff <= prod_ff[33:0];
         end
         ST_VELY: begin
            acc_x_ff <= $signed({prod_ff[49:0], 1'b0});
         end
         ST_ACCX: begin
            acc_y_ff <= $signed({prod_ff[49:0], 1'b0});
         end
         ST_ACCY: begin
            acc_x_ff <= acc_x_ff + 51'(prod_ff);
         end
         ST_ROUNDX: begin
            acc_y_ff <= acc_y_ff + 51'(prod_ff);
            inc_x_ff <= rnd_x[50:25];
         end
         ST_ROUNDY: begin
            inc_y_ff <= rnd_y[50:25];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_pos_x       <= pos_x_ff;
         rsp_pos_y       <= new_pos_y;
         rsp_depth_out   <= q_head.depth;
         rsp_roll_out    <= q_head.roll;
         rsp_pitch_out   <= q_head.pitch;
         rsp_heading_out <= q_head.heading;
      end
   end

endmodule
